[design/pose_to_turn_move_turn_core_assert.svh]
// Assertion macros for the pose-to-turn-move-turn block.
// Used by the port checker; expects clk_i and rst_ni in scope.
`ifndef POSE_TO_TURN_MOVE_TURN_CORE_ASSERT_SVH
`define POSE_TO_TURN_MOVE_TURN_CORE_ASSERT_SVH

// Clocked check, disabled while reset is asserted.
`define PTMT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PTMT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[design/ptmt_pkg.sv]
// Shared types, constants and tables for the pose-to-turn-move-turn block.
// No dependencies.
package ptmt_pkg;

  localparam int ANGLE_BITS    = 16;
  localparam int CORDIC_STAGES = 16;

  // Front pipeline stage map
  localparam int NORM_FIRST = 2;
  localparam int NORM_LAST  = 8;
  localparam int CR_FIRST   = 9;
  localparam int CR_END     = CR_FIRST + CORDIC_STAGES;
  localparam int SQ_BITS    = 34;
  localparam int SQ_FIRST   = 3;
  localparam int SQ_END     = SQ_FIRST + SQ_BITS;
  localparam int DEC_IDX    = (SQ_END > CR_END) ? SQ_END : CR_END + 1;
  localparam int NSTG       = DEC_IDX + 1;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = 2;

  typedef enum logic [1:0] {
    CMD_TURN     = 2'd0,
    CMD_MOVE     = 2'd1,
    CMD_NOMOTION = 2'd2
  } cmd_kind_e;

  typedef enum logic [1:0] {
    CFG_RIGHT_HANDED = 2'd0,
    CFG_DEADBAND     = 2'd1,
    CFG_MIN_MOVE     = 2'd2
  } cfg_idx_e;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic        rh;
    logic [9:0]  deadband;
    logic [32:0] min_move;
  } cfg_t;

  typedef struct packed {
    logic                         t1_en;
    logic signed [ANGLE_BITS-1:0] t1;
    logic                         mv_en;
    logic [32:0]                  move_dist;
    logic                         t2_en;
    logic signed [ANGLE_BITS-1:0] t2;
  } plan_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[design/ptmt_front.sv]
// Front part: accepts requests and classifies them into a command plan.
// Depends on ptmt_pkg. Runs sqrt and CORDIC as one stallable pipeline.
module ptmt_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ptmt_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [31:0]   start_x_i,
  input  logic signed [31:0]   start_y_i,
  input  logic [15:0]          start_heading_i,
  input  logic signed [31:0]   finish_x_i,
  input  logic signed [31:0]   finish_y_i,
  input  logic [15:0]          finish_heading_i,
  input  logic                 q_full_i,
  output logic                 push_o,
  output ptmt_pkg::plan_t      plan_o
);
  import ptmt_pkg::*;

  typedef struct packed {
    logic signed [32:0]      dx;
    logic signed [32:0]      dy;
    logic [ANGLE_BITS-1:0]   hs;
    logic [ANGLE_BITS-1:0]   hf;
    logic                    zero;
    logic                    ah;
    logic                    bh;
    logic [31:0]             al;
    logic [31:0]             bl;
    logic [63:0]             aprod;
    logic [63:0]             bprod;
    logic [67:0]             rem;
    logic [33:0]             root;
    logic signed [63:0]      cx;
    logic signed [63:0]      cy;
    logic [31:0]             cz;
    logic [ANGLE_BITS-1:0]   hd;
    plan_t                   plan;
  } stage_t;

  function automatic logic keep_turn(input logic signed [ANGLE_BITS-1:0] t,
                                     input logic [9:0] db);
    logic [ANGLE_BITS-1:0] mag;
    mag = t[ANGLE_BITS-1] ? ANGLE_BITS'(-t) : ANGLE_BITS'(t);
    return 32'(mag) > 32'(db);
  endfunction

  function automatic stage_t stg_step(input int idx, input stage_t s, input cfg_t c);
    stage_t                       r;
    logic [32:0]                  adx;
    logic [32:0]                  ady;
    logic signed [63:0]           vx;
    logic signed [63:0]           vy;
    logic signed [63:0]           xs;
    logic signed [63:0]           ys;
    logic signed [63:0]           lim;
    logic [69:0]                  trial;
    logic [31:0]                  zr;
    logic signed [ANGLE_BITS-1:0] t0;
    logic signed [ANGLE_BITS-1:0] t1;
    logic signed [ANGLE_BITS-1:0] t2;
    logic [32:0]                  dist_v;
    int                           b;
    int                           sh;
    int                           it;
    r = s;
    if (idx == 1) begin
      adx = s.dx[32] ? 33'(-s.dx) : 33'(s.dx);
      ady = s.dy[32] ? 33'(-s.dy) : 33'(s.dy);
      r.ah = adx[32];
      r.al = adx[31:0];
      r.bh = ady[32];
      r.bl = ady[31:0];
      r.aprod = 64'(adx[31:0]) * 64'(adx[31:0]);
      r.bprod = 64'(ady[31:0]) * 64'(ady[31:0]);
      r.zero = (s.dx == '0) && (s.dy == '0);
      vx = c.rh ? 64'(s.dx) : 64'(s.dy);
      vy = c.rh ? 64'(s.dy) : 64'(s.dx);
      if (vx < 0) begin
        r.cx = -vx;
        r.cy = -vy;
        r.cz = 32'h8000_0000;
      end else begin
        r.cx = vx;
        r.cy = vy;
        r.cz = '0;
      end
    end
    if (idx == 2) begin
      r.rem = 68'(s.aprod) + 68'(s.bprod)
            + (s.ah ? ((68'(s.al) << 33) + (68'd1 << 64)) : 68'd0)
            + (s.bh ? ((68'(s.bl) << 33) + (68'd1 << 64)) : 68'd0);
      r.root = '0;
    end
    // Normalize: binary search for the largest shift that stays inside
    if (idx >= NORM_FIRST && idx <= NORM_LAST) begin
      sh  = (idx < NORM_LAST) ? (32 >> (idx - NORM_FIRST)) : 1;
      lim = (idx < NORM_LAST) ? (64'sd1 <<< (51 - sh)) : (64'sd1 <<< 51);
      if (s.cx < lim && s.cy < lim && s.cy > -lim) begin
        r.cx = s.cx <<< sh;
        r.cy = s.cy <<< sh;
      end
    end
    if (idx >= CR_FIRST && idx < CR_END) begin
      it = idx - CR_FIRST;
      xs = s.cx >>> it;
      ys = s.cy >>> it;
      if (s.cy > 0) begin
        r.cx = s.cx + ys;
        r.cy = s.cy - xs;
        r.cz = s.cz + ATAN_TURNS[it];
      end else begin
        r.cx = s.cx - ys;
        r.cy = s.cy + xs;
        r.cz = s.cz - ATAN_TURNS[it];
      end
    end
    if (idx == CR_END) begin
      zr = s.cz + (32'd1 << (31 - ANGLE_BITS));
      r.hd = s.zero ? s.hs : zr[31 -: ANGLE_BITS];
    end
    if (idx >= SQ_FIRST && idx < SQ_END) begin
      b = SQ_BITS - 1 - (idx - SQ_FIRST);
      trial = (70'(s.root) << (b + 1)) | (70'd1 << (2 * b));
      if (trial <= 70'(s.rem)) begin
        r.rem  = 68'(70'(s.rem) - trial);
        r.root = s.root | (34'd1 << b);
      end
    end
    if (idx == DEC_IDX) begin
      dist_v = s.root[32:0];
      t0 = ANGLE_BITS'(s.hf - s.hs);
      t1 = ANGLE_BITS'(s.hd - s.hs);
      t2 = ANGLE_BITS'(s.hf - s.hd);
      r.plan.move_dist = dist_v;
      if (dist_v >= c.min_move) begin
        r.plan.mv_en = 1'b1;
        r.plan.t1    = t1;
        r.plan.t1_en = keep_turn(t1, c.deadband);
        r.plan.t2    = t2;
        r.plan.t2_en = keep_turn(t2, c.deadband);
      end else begin
        r.plan.mv_en = 1'b0;
        r.plan.t1    = t0;
        r.plan.t1_en = keep_turn(t0, c.deadband);
        r.plan.t2    = '0;
        r.plan.t2_en = 1'b0;
      end
    end
    return r;
  endfunction

  logic [NSTG-1:0] valid_q;
  stage_t          stage_q [NSTG];
  stage_t          st0;
  logic            advance;

  assign advance    = !(valid_q[NSTG-1] && q_full_i);
  assign in_stall_o = !advance;
  assign push_o     = valid_q[NSTG-1] && !q_full_i;
  assign plan_o     = stage_q[NSTG-1].plan;

  always_comb begin
    st0    = '0;
    st0.dx = 33'(finish_x_i) - 33'(start_x_i);
    st0.dy = 33'(finish_y_i) - 33'(start_y_i);
    st0.hs = start_heading_i[ANGLE_BITS-1:0];
    st0.hf = finish_heading_i[ANGLE_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (advance) begin
      valid_q <= {valid_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stage_q[0] <= st0;
      for (int i = 1; i < NSTG; i++) begin
        stage_q[i] <= stg_step(i, stage_q[i-1], cfg_i);
      end
    end
  end

endmodule

[design/ptmt_queue.sv]
// Short plan queue between the front and back parts.
// Depends on ptmt_pkg.
module ptmt_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  ptmt_pkg::plan_t       plan_i,
  input  logic                  pop_i,
  output ptmt_pkg::plan_t       plan_o,
  output ptmt_pkg::q_status_t   status_o
);
  import ptmt_pkg::*;

  plan_t           mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wr_q;
  logic [Q_AW-1:0] rd_q;
  logic [Q_AW:0]   cnt_q;

  assign plan_o         = mem_q[rd_q];
  assign status_o.full  = (cnt_q == (Q_AW+1)'(Q_DEPTH));
  assign status_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i) rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= plan_i;
  end

endmodule

[design/ptmt_back.sv]
// Back part: walks a plan and issues its commands into the output register.
// Depends on ptmt_pkg.
module ptmt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptmt_pkg::plan_t   plan_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [1:0]        command_kind_o,
  output logic signed [15:0] turn_amount_o,
  output logic [32:0]       move_distance_o,
  output logic              last_of_run_o
);
  import ptmt_pkg::*;

  logic             out_valid_q;
  cmd_kind_e        kind_q;
  logic [15:0]      turn_q;
  logic [32:0]      dist_q;
  logic             last_q;
  logic [1:0]       slot_q;

  logic [2:0]       en;
  logic [2:0]       left;
  logic [1:0]       k;
  logic             last;
  logic             load;
  cmd_kind_e        kind_d;
  logic [15:0]      turn_d;
  logic [32:0]      dist_d;

  always_comb begin
    en = {plan_i.t2_en, plan_i.mv_en, plan_i.t1_en};
    case (slot_q)
      2'd0:    left = en;
      2'd1:    left = en & 3'b110;
      default: left = en & 3'b100;
    endcase
    k = left[0] ? 2'd0 : (left[1] ? 2'd1 : 2'd2);
    case (k)
      2'd0:    last = (left[2:1] == 2'b00);
      2'd1:    last = !left[2];
      default: last = 1'b1;
    endcase
    kind_d = CMD_TURN;
    turn_d = '0;
    dist_d = '0;
    if (en == 3'b000) begin
      kind_d = CMD_NOMOTION;
      last   = 1'b1;
    end else begin
      case (k)
        2'd0:    turn_d = 16'(plan_i.t1);
        2'd1: begin
          kind_d = CMD_MOVE;
          dist_d = plan_i.move_dist;
        end
        default: turn_d = 16'(plan_i.t2);
      endcase
    end
  end

  assign load  = !out_valid_q || !out_stall_i;
  assign pop_o = load && !empty_i && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      slot_q      <= '0;
    end else if (load) begin
      out_valid_q <= !empty_i;
      if (!empty_i) slot_q <= last ? 2'd0 : k + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && !empty_i) begin
      kind_q <= kind_d;
      turn_q <= turn_d;
      dist_q <= dist_d;
      last_q <= last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign command_kind_o  = kind_q;
  assign turn_amount_o   = turn_q;
  assign move_distance_o = dist_q;
  assign last_of_run_o   = last_q;

endmodule

[design/pose_to_turn_move_turn_core.sv]
// Top level of the pose-to-turn-move-turn motion splitter.
// Depends on ptmt_pkg, ptmt_front, ptmt_queue and ptmt_back.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request item: start and
//   finish pose, Q16.16 positions and binary-angle headings. Output channel
//   (out_valid_o / out_stall_i) gives one command item per accepted beat:
//   turn, forward move or no motion, with last_of_run_o on the final one.
//   A request yields one to three commands.
//   Path: an accepted request reaches its first command through the front
//   pipeline of 38 stages, the queue write and the output register; stalls hold it.
//   Throughput: the front pipeline takes a request every cycle unless
//   in_stall_o is high; the output port issues one command per cycle while
//   not stalled and plans wait, so a request uses one output beat per command.
//   Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i in
//   the same edge; write only while the block is idle.
//   Reset: clears all valid state and loads the register defaults
//   (left-handed, deadband 10, minimum move 1.0).
//   Stall: a stalled output holds its command; the four-entry plan queue
//   absorbs the front, and once it is full and a plan waits at the end of
//   the pipeline, in_stall_o rises and the whole pipeline holds.
module pose_to_turn_move_turn_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [32:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] start_x_i,
  input  logic signed [31:0] start_y_i,
  input  logic [15:0]        start_heading_i,
  input  logic signed [31:0] finish_x_i,
  input  logic signed [31:0] finish_y_i,
  input  logic [15:0]        finish_heading_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         command_kind_o,
  output logic signed [15:0] turn_amount_o,
  output logic [32:0]        move_distance_o,
  output logic               last_of_run_o
);
  import ptmt_pkg::*;

  cfg_t      cfg_q;
  plan_t     plan_in;
  plan_t     plan_head;
  q_status_t q_status;
  logic      push;
  logic      pop;

  // Register file: write on enable, ignore unknown indexes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rh       <= 1'b0;
      cfg_q.deadband <= 10'd10;
      cfg_q.min_move <= 33'd65536;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RIGHT_HANDED: cfg_q.rh       <= cfg_data_i[0];
        CFG_DEADBAND:     cfg_q.deadband <= cfg_data_i[9:0];
        CFG_MIN_MOVE:     cfg_q.min_move <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Front: distance and heading pipeline, ends in a plan per request
  ptmt_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .start_x_i        (start_x_i),
    .start_y_i        (start_y_i),
    .start_heading_i  (start_heading_i),
    .finish_x_i       (finish_x_i),
    .finish_y_i       (finish_y_i),
    .finish_heading_i (finish_heading_i),
    .q_full_i         (q_status.full),
    .push_o           (push),
    .plan_o           (plan_in)
  );

  // Queue: decouples the pipeline from the command issue rate
  ptmt_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .plan_i   (plan_in),
    .pop_i    (pop),
    .plan_o   (plan_head),
    .status_o (q_status)
  );

  // Back: one command per cycle into the output register, unless stalled or the queue is empty
  ptmt_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .plan_i          (plan_head),
    .empty_i         (q_status.empty),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .command_kind_o  (command_kind_o),
    .turn_amount_o   (turn_amount_o),
    .move_distance_o (move_distance_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

[design/ptmt_checker.sv]
// Port-level checks for pose_to_turn_move_turn_core, attached by bind.
// Depends on ptmt_pkg and pose_to_turn_move_turn_core_assert.svh.
`include "pose_to_turn_move_turn_core_assert.svh"

module ptmt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [1:0]         cfg_idx_i,
  input logic [32:0]        cfg_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic signed [31:0] start_x_i,
  input logic signed [31:0] start_y_i,
  input logic [15:0]        start_heading_i,
  input logic signed [31:0] finish_x_i,
  input logic signed [31:0] finish_y_i,
  input logic [15:0]        finish_heading_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         command_kind_o,
  input logic signed [15:0] turn_amount_o,
  input logic [32:0]        move_distance_o,
  input logic               last_of_run_o
);
  import ptmt_pkg::*;

  `PTMT_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")
  `PTMT_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(command_kind_o) && $stable(turn_amount_o) && $stable(move_distance_o) && $stable(last_of_run_o), "stalled command changed")
  `PTMT_ASSERT(a_nomotion_last, out_valid_o && command_kind_o == CMD_NOMOTION |-> last_of_run_o && turn_amount_o == 16'sd0 && move_distance_o == 33'd0, "no-motion item malformed")
  `PTMT_ASSERT(a_turn_nonzero, out_valid_o && command_kind_o == CMD_TURN |-> turn_amount_o != 16'sd0 && move_distance_o == 33'd0, "turn item malformed")

endmodule

bind pose_to_turn_move_turn_core ptmt_checker u_ptmt_checker (.*);
